// ===== hdl/tdp_pkg.sv =====
// shared types and constants for the trial division prime test
`default_nettype none
package tdp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCREEN,
		ST_BOUND,
		ST_DIV,
		ST_DONE
	} tdp_state_t;

	typedef enum logic [1:0] {
		PH_THREE,
		PH_LO,
		PH_HI
	} tdp_phase_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_status_t;

	localparam int SMALL_PRIME_MAX = 3;
	localparam int SMALL_NON_PRIME = 1;
	localparam int FIRST_ODD_PRIME = 3;
	localparam int FIRST_DIVISOR   = 5;
	localparam int DIVISOR_STEP    = 6;
	localparam int PAIR_GAP        = 2;
	localparam int SQ_STEP_MUL     = 2 * DIVISOR_STEP;
	localparam int SQ_STEP_ADD     = DIVISOR_STEP * DIVISOR_STEP;

endpackage
`default_nettype wire

// ===== hdl/tdp_serial_div.sv =====
// radix-2 restoring divider that yields the remainder one dividend bit per cycle
`default_nettype none
module tdp_serial_div
	import tdp_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int DIV_WIDTH  = 18
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] dividend,
	input  wire logic [DIV_WIDTH-1:0]  divisor,
	output div_status_t                status
);

	localparam int CW = $clog2(DATA_WIDTH + 1);

	logic [DATA_WIDTH-1:0] shift_q;
	logic [DIV_WIDTH-1:0]  rem_q;
	logic [DIV_WIDTH-1:0]  dvs_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIV_WIDTH:0]    trial;
	logic [DIV_WIDTH:0]    diff;

	assign trial = {rem_q, shift_q[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			dvs_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[DATA_WIDTH-2:0], 1'b0};
			if (!diff[DIV_WIDTH]) begin
				rem_q <= diff[DIV_WIDTH-1:0];
			end else begin
				rem_q <= trial[DIV_WIDTH-1:0];
			end
		end
	end

	assign status.done     = done_q;
	assign status.rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

// ===== hdl/trial_division_prime_test.sv =====
// top level of the trial division prime test
// Tests one signed candidate word at a time for primality by trial division with the
// divisor pairs 6k-1 and 6k+1, and returns one flag bit per candidate. Negative values,
// 0 to 3 and even values are settled by the screen alone. Every other candidate runs
// through a bit-serial remainder unit, first for 3 and then for each pair d, d+2 while
// d*d does not exceed the candidate, so a 31-bit prime takes roughly 7700 pairs.
// The square of d is kept incrementally with one update per pair.
// A new candidate is taken once the previous flag has moved to the output register,
// which holds it until the receiver takes it.
`default_nettype none
module trial_division_prime_test
	import tdp_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [DATA_WIDTH-1:0] candidate,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       is_prime_flag
);

	localparam int DW = DATA_WIDTH / 2 + 2;
	localparam int SW = DATA_WIDTH + 1;

	tdp_state_t  state_q, state_d;
	tdp_phase_t  phase_q;
	div_status_t div_st;

	logic [DATA_WIDTH-1:0] v_q;
	logic [DW-1:0]         d_q;
	logic [SW-1:0]         sq_q;
	logic                  res_q;
	logic                  out_valid_q;
	logic                  flag_q;

	logic                  div_start;
	logic [DW-1:0]         div_divisor;
	logic                  accept;
	logic                  load_out;
	logic                  screen_done;
	logic                  screen_res;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_comb begin
		screen_done = 1'b1;
		screen_res  = 1'b0;
		if (v_q[DATA_WIDTH-1]) begin
			screen_res = 1'b0;
		end else if (v_q <= DATA_WIDTH'(SMALL_PRIME_MAX)) begin
			screen_res = (v_q > DATA_WIDTH'(SMALL_NON_PRIME));
		end else if (!v_q[0]) begin
			screen_res = 1'b0;
		end else begin
			screen_done = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		div_divisor = d_q;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCREEN;
			end
			ST_SCREEN: begin
				if (screen_done) begin
					state_d = ST_DONE;
				end else begin
					div_start   = 1'b1;
					div_divisor = DW'(FIRST_ODD_PRIME);
					state_d     = ST_DIV;
				end
			end
			ST_BOUND: begin
				if (sq_q > SW'(v_q)) begin
					state_d = ST_DONE;
				end else begin
					div_start   = 1'b1;
					div_divisor = d_q;
					state_d     = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					if (div_st.rem_zero) begin
						state_d = ST_DONE;
					end else if (phase_q == PH_LO) begin
						div_start   = 1'b1;
						div_divisor = d_q + DW'(PAIR_GAP);
					end else begin
						state_d = ST_BOUND;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) v_q <= candidate;
		unique case (state_q)
			ST_SCREEN: begin
				res_q   <= screen_res;
				phase_q <= PH_THREE;
			end
			ST_BOUND: begin
				res_q   <= 1'b1;
				phase_q <= PH_LO;
			end
			ST_DIV: begin
				if (div_st.done) begin
					res_q <= 1'b0;
					case (phase_q)
						PH_THREE: begin
							d_q  <= DW'(FIRST_DIVISOR);
							sq_q <= SW'(FIRST_DIVISOR * FIRST_DIVISOR);
						end
						PH_LO: phase_q <= PH_HI;
						default: begin
							d_q  <= d_q + DW'(DIVISOR_STEP);
							sq_q <= sq_q + SW'(d_q) * SW'(SQ_STEP_MUL) + SW'(SQ_STEP_ADD);
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) flag_q <= res_q;
	end

	tdp_serial_div #(
		.DATA_WIDTH(DATA_WIDTH),
		.DIV_WIDTH (DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(v_q),
		.divisor (div_divisor),
		.status  (div_st)
	);

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign is_prime_flag = flag_q;

endmodule
`default_nettype wire

// ===== hdl/tdp_checker.sv =====
// port-level checks for the trial division prime test and their bind
`default_nettype none
module tdp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic is_prime_flag
);

	// an accepted word keeps the input closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after accepting a word");

	// with the input open nothing is pending, so a taken result is not followed by another
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !out_valid)
		else $error("result shown with no word in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(is_prime_flag))
		else $error("stalled result changed");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (.*);
`default_nettype wire
